@@ hw/rtl/tsfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_pkg
// Shared constants and types for the TCP SYN fingerprint extractor.
// ----------------------------------------------------------------------------
package tsfe_pkg;

  // Ethernet header length in bytes; the ethertype is its last two bytes
  localparam logic [7:0] ETH_HEADER_BYTES = 8'd14;

  localparam logic [7:0] ETHERTYPE_HI = 8'h08;
  localparam logic [7:0] ETHERTYPE_LO = 8'h00;
  localparam logic [3:0] IP_VERSION4  = 4'd4;
  localparam logic [3:0] MIN_WORDS    = 4'd5;
  localparam logic [7:0] PROTO_TCP    = 8'd6;

  // TCP option kinds
  localparam logic [7:0] OPT_EOL   = 8'd0;
  localparam logic [7:0] OPT_NOP   = 8'd1;
  localparam logic [7:0] OPT_MSS   = 8'd2;
  localparam logic [7:0] OPT_WSCL  = 8'd3;
  localparam logic [7:0] OPT_SACKP = 8'd4;
  localparam logic [7:0] OPT_TSTMP = 8'd8;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_IPV4  = 3'd1,
    ST_BAD_VER   = 3'd2,
    ST_SHORT_IP  = 3'd3,
    ST_NOT_TCP   = 3'd4,
    ST_SHORT_TCP = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  localparam int ResultBits  = 97;
  localparam int ResultBytes = (ResultBits + 7) / 8;
  localparam int TdataBits   = ResultBytes * 8;

  typedef struct packed {
    logic [7:0]  window_scale;
    logic [15:0] max_segment;
    logic [4:0]  option_flags;
    logic [6:0]  header_length_sum;
    logic        ack_set;
    logic        dont_fragment;
    logic [15:0] window;
    logic [7:0]  ttl;
    logic [31:0] source_ip;
    logic [2:0]  status;
  } result_t;

endpackage

@@ hw/rtl/tcp_syn_fingerprint_extract_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_syn_fingerprint_extract_core
// Passive TCP/IP fingerprint field extractor for Ethernet frames.
// ----------------------------------------------------------------------------
// Frames enter one byte per item starting at the destination MAC, with tlast
// on the final byte. Bytes may follow back to back while the queue has room;
// the header walk is a single pass of per-byte logic on the parse state
// registers. The frame result is written on the tlast byte into a two-entry
// output queue; if the queue was empty it shows on the master side next cycle.
// Input stalls only when both queue entries hold results not yet taken.
// No reset sweep is needed: the block takes items in the cycle after reset.
module tcp_syn_fingerprint_extract_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,   // [7:0] data_byte
  input  logic                                s_tlast,   // last_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] status, [34:3] source_ip, [42:35] ttl, [58:43] window,
  // [59] dont_fragment, [60] ack_set, [67:61] header_length_sum,
  // [72:68] option_flags, [88:73] max_segment, [96:89] window_scale, rest 0
  output logic [tsfe_pkg::TdataBits-1:0]      m_tdata
);

  logic              accept;
  logic              res_valid;
  tsfe_pkg::result_t res;
  tsfe_pkg::result_t out_res;

  assign accept = s_tvalid & s_tready;

  tsfe_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  tsfe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {{(tsfe_pkg::TdataBits - tsfe_pkg::ResultBits){1'b0}}, out_res};

endmodule

@@ hw/rtl/tsfe_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_parser
// Per-byte header walker: holds the parse state and builds the frame result
// on the last byte.
// ----------------------------------------------------------------------------
module tsfe_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                res_valid,
  output tsfe_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_ETH  = 3'd0,
    PH_IP   = 3'd1,
    PH_TCP  = 3'd2,
    PH_KIND = 3'd3,
    PH_LEN  = 3'd4,
    PH_BODY = 3'd5,
    PH_DONE = 3'd6,
    PH_ERR  = 3'd7
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_pos, byte_pos_next;
  logic [3:0]  ip_words, ip_words_next;
  logic [3:0]  tcp_words, tcp_words_next;
  logic [7:0]  opt_kind, opt_kind_next;
  logic [7:0]  opt_skip, opt_skip_next;
  logic [7:0]  held_ttl, held_ttl_next;
  logic [15:0] held_window, held_window_next;
  logic [31:0] held_source, held_source_next;
  logic [6:0]  held_flags, held_flags_next;
  logic [15:0] held_mss, held_mss_next;
  logic [7:0]  held_scale, held_scale_next;
  logic [2:0]  held_status, held_status_next;

  logic [7:0]  ip_end, tcp_end, ip_off, tcp_off, skip_dec;
  logic        do_kind, fixed_len;
  logic [2:0]  status;

  always_comb begin
    phase_next       = phase;
    ip_words_next    = ip_words;
    tcp_words_next   = tcp_words;
    opt_kind_next    = opt_kind;
    opt_skip_next    = opt_skip;
    held_ttl_next    = held_ttl;
    held_window_next = held_window;
    held_source_next = held_source;
    held_flags_next  = held_flags;
    held_mss_next    = held_mss;
    held_scale_next  = held_scale;
    held_status_next = held_status;

    ip_end   = tsfe_pkg::ETH_HEADER_BYTES + {2'b00, ip_words, 2'b00};
    ip_off   = byte_pos - tsfe_pkg::ETH_HEADER_BYTES;
    tcp_off  = byte_pos - ip_end;
    skip_dec = opt_skip - 8'd1;
    fixed_len = (opt_kind == tsfe_pkg::OPT_SACKP) || (opt_kind == tsfe_pkg::OPT_MSS) ||
                (opt_kind == tsfe_pkg::OPT_WSCL);
    // a short length byte on a variable-size option is read as the next kind
    do_kind = (phase == PH_KIND) ||
              ((phase == PH_LEN) && !fixed_len && (data_byte < 8'd2));

    unique case (phase)
      PH_ETH: begin
        if (byte_pos == tsfe_pkg::ETH_HEADER_BYTES - 8'd2) begin
          if (data_byte != tsfe_pkg::ETHERTYPE_HI) begin
            held_status_next = tsfe_pkg::ST_NOT_IPV4;
            phase_next       = PH_ERR;
          end
        end else if (byte_pos == tsfe_pkg::ETH_HEADER_BYTES - 8'd1) begin
          if (data_byte != tsfe_pkg::ETHERTYPE_LO) begin
            held_status_next = tsfe_pkg::ST_NOT_IPV4;
            phase_next       = PH_ERR;
          end else begin
            phase_next = PH_IP;
          end
        end
      end
      PH_IP: begin
        if (ip_off == 8'd0) begin
          ip_words_next = data_byte[3:0];
          if (data_byte[7:4] != tsfe_pkg::IP_VERSION4) begin
            held_status_next = tsfe_pkg::ST_BAD_VER;
            phase_next       = PH_ERR;
          end else if (data_byte[3:0] < tsfe_pkg::MIN_WORDS) begin
            held_status_next = tsfe_pkg::ST_SHORT_IP;
            phase_next       = PH_ERR;
          end
        end else if (ip_off == 8'd6) begin
          if (data_byte[6]) held_flags_next[5] = 1'b1;
        end else if (ip_off == 8'd8) begin
          held_ttl_next = data_byte;
        end else if (ip_off == 8'd9) begin
          if (data_byte != tsfe_pkg::PROTO_TCP) begin
            held_status_next = tsfe_pkg::ST_NOT_TCP;
            phase_next       = PH_ERR;
          end
        end else if (ip_off >= 8'd12 && ip_off <= 8'd15) begin
          held_source_next = {held_source[23:0], data_byte};
        end
        if (phase_next == PH_IP && byte_pos == ip_end - 8'd1) phase_next = PH_TCP;
      end
      PH_TCP: begin
        if (tcp_off == 8'd12) begin
          tcp_words_next = data_byte[7:4];
          if (data_byte[7:4] < tsfe_pkg::MIN_WORDS) begin
            held_status_next = tsfe_pkg::ST_SHORT_TCP;
            phase_next       = PH_ERR;
          end
        end else if (tcp_off == 8'd13) begin
          if (data_byte[4]) held_flags_next[6] = 1'b1;
        end else if (tcp_off == 8'd14) begin
          held_window_next = {data_byte, 8'h00};
        end else if (tcp_off == 8'd15) begin
          held_window_next = {held_window[15:8], data_byte};
        end
      end
      PH_KIND, PH_LEN, PH_BODY: begin
        if (do_kind) begin
          opt_kind_next = data_byte;
          priority case (data_byte)
            tsfe_pkg::OPT_EOL:   phase_next = PH_BODY;  // soak up rest of header
            tsfe_pkg::OPT_NOP: begin
              held_flags_next[0] = 1'b1;
              phase_next         = PH_KIND;
            end
            tsfe_pkg::OPT_SACKP: begin
              held_flags_next[1] = 1'b1;
              phase_next         = PH_LEN;
            end
            tsfe_pkg::OPT_TSTMP: begin
              held_flags_next[2] = 1'b1;
              phase_next         = PH_LEN;
            end
            tsfe_pkg::OPT_MSS: begin
              held_flags_next[3] = 1'b1;
              held_mss_next      = 16'h0000;
              phase_next         = PH_LEN;
            end
            tsfe_pkg::OPT_WSCL: begin
              held_flags_next[4] = 1'b1;
              held_scale_next    = 8'h00;
              phase_next         = PH_LEN;
            end
            default: phase_next = PH_LEN;
          endcase
        end else if (phase == PH_LEN) begin
          if (opt_kind == tsfe_pkg::OPT_SACKP) begin
            phase_next = PH_KIND;
          end else if (opt_kind == tsfe_pkg::OPT_MSS) begin
            opt_skip_next = 8'd2;
            phase_next    = PH_BODY;
          end else if (opt_kind == tsfe_pkg::OPT_WSCL) begin
            opt_skip_next = 8'd1;
            phase_next    = PH_BODY;
          end else begin
            opt_skip_next = data_byte - 8'd2;
            phase_next    = (data_byte == 8'd2) ? PH_KIND : PH_BODY;
          end
        end else if (opt_kind != tsfe_pkg::OPT_EOL) begin
          if (opt_kind == tsfe_pkg::OPT_MSS) begin
            if (opt_skip == 8'd2) held_mss_next = {data_byte, 8'h00};
            else                  held_mss_next = {held_mss[15:8], held_mss[7:0] | data_byte};
          end else if (opt_kind == tsfe_pkg::OPT_WSCL) begin
            held_scale_next = data_byte;
          end
          opt_skip_next = skip_dec;
          if (skip_dec == 8'd0) phase_next = PH_KIND;
        end
      end
      PH_DONE, PH_ERR: begin
      end
      default: begin
      end
    endcase

    tcp_end = ip_end + {2'b00, tcp_words_next, 2'b00};

    if (phase == PH_TCP && phase_next == PH_TCP && tcp_off == 8'd19)
      phase_next = (byte_pos == tcp_end - 8'd1) ? PH_DONE : PH_KIND;
    if ((phase == PH_KIND || phase == PH_LEN || phase == PH_BODY) &&
        byte_pos == tcp_end - 8'd1)
      phase_next = PH_DONE;

    byte_pos_next = (byte_pos != 8'hFF) ? byte_pos + 8'd1 : byte_pos;
  end

  // frame result, taken from the state after this byte
  always_comb begin
    if (phase_next == PH_ERR)       status = held_status_next;
    else if (phase_next != PH_DONE) status = tsfe_pkg::ST_TRUNC;
    else                            status = tsfe_pkg::ST_OK;

    res = '0;
    res.status = status;
    if (status == tsfe_pkg::ST_OK) begin
      res.source_ip         = held_source_next;
      res.ttl               = held_ttl_next;
      res.window            = held_window_next;
      res.dont_fragment     = held_flags_next[5];
      res.ack_set           = held_flags_next[6];
      res.header_length_sum = {1'b0, ip_words_next, 2'b00} + {1'b0, tcp_words_next, 2'b00};
      res.option_flags      = held_flags_next[4:0];
      res.max_segment       = held_mss_next;
      res.window_scale      = held_scale_next;
    end
  end

  assign res_valid = accept & last_byte;

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase       <= PH_ETH;
      byte_pos    <= '0;
      ip_words    <= '0;
      tcp_words   <= '0;
      opt_kind    <= '0;
      opt_skip    <= '0;
      held_ttl    <= '0;
      held_window <= '0;
      held_source <= '0;
      held_flags  <= '0;
      held_mss    <= '0;
      held_scale  <= '0;
      held_status <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_pos    <= byte_pos_next;
      ip_words    <= ip_words_next;
      tcp_words   <= tcp_words_next;
      opt_kind    <= opt_kind_next;
      opt_skip    <= opt_skip_next;
      held_ttl    <= held_ttl_next;
      held_window <= held_window_next;
      held_source <= held_source_next;
      held_flags  <= held_flags_next;
      held_mss    <= held_mss_next;
      held_scale  <= held_scale_next;
      held_status <= held_status_next;
    end
  end

endmodule

@@ hw/rtl/tsfe_out_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfe_out_buf
// Two-entry result queue between the parser and the output stream.
// ----------------------------------------------------------------------------
module tsfe_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tsfe_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output tsfe_pkg::result_t out_data
);

  tsfe_pkg::result_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign has_room  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule
